@@ design/b58d_pkg.sv @@
// Shared types, sizes and the character decode function for the Base58 decoder.
package b58d_pkg;

    localparam int MAX_BYTES = 32;
    localparam int VAL_W     = 8 * MAX_BYTES;
    localparam int PROD_W    = VAL_W + 6;
    localparam int LO_W      = $clog2(MAX_BYTES + 1);
    localparam int TOT_W     = $clog2(2 * MAX_BYTES + 1);
    localparam int BIDX_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } char_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       last_out;
    } byte_rsp_t;

    typedef logic [MAX_BYTES-1:0][7:0] value_t;

    // Finished string handed from the accumulator to the emitter
    typedef struct packed {
        status_t            err;
        logic [TOT_W-1:0]   total;
        logic [LO_W-1:0]    sig;
        value_t             value;
    } snap_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] digit;
    } digit_t;

    // Bitcoin alphabet: 1-9 A-H J-N P-Z a-k m-z
    function automatic digit_t b58_digit(input logic [7:0] c);
        digit_t d;
        d.ok    = 1'b1;
        d.digit = 6'd0;
        if (c >= 8'h31 && c <= 8'h39)
            d.digit = 6'(c - 8'h31);
        else if (c >= 8'h41 && c <= 8'h48)
            d.digit = 6'(c - 8'h41 + 8'd9);
        else if (c >= 8'h4A && c <= 8'h4E)
            d.digit = 6'(c - 8'h4A + 8'd17);
        else if (c >= 8'h50 && c <= 8'h5A)
            d.digit = 6'(c - 8'h50 + 8'd22);
        else if (c >= 8'h61 && c <= 8'h6B)
            d.digit = 6'(c - 8'h61 + 8'd33);
        else if (c >= 8'h6D && c <= 8'h7A)
            d.digit = 6'(c - 8'h6D + 8'd44);
        else
            d.ok = 1'b0;
        return d;
    endfunction

endpackage

@@ design/b58d_accum.sv @@
// Big-number accumulator: value = value * 58 + digit, leading '1' count, error capture.
module b58d_accum (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  b58d_pkg::char_req_t  req,
    output b58d_pkg::snap_t      snap
);

    b58d_pkg::value_t                 val_reg, val_next;
    logic [b58d_pkg::LO_W-1:0]        lo_reg, lo_next;
    logic [b58d_pkg::LO_W-1:0]        sig_reg, sig_next;
    logic                             run_reg, run_next;
    b58d_pkg::status_t                err_reg, err_next;
    b58d_pkg::digit_t                 dg;
    logic [b58d_pkg::PROD_W-1:0]      ext, prod;
    b58d_pkg::value_t                 prod_bytes;
    logic [b58d_pkg::TOT_W-1:0]       total;

    always_comb
    begin
        dg         = b58d_pkg::b58_digit(req.char_code);
        ext        = b58d_pkg::PROD_W'(val_reg);
        // times 58 as shift-add: 32 + 16 + 8 + 2
        prod       = (ext << 5) + (ext << 4) + (ext << 3) + (ext << 1)
                   + b58d_pkg::PROD_W'(dg.digit);
        prod_bytes = prod[b58d_pkg::VAL_W-1:0];

        val_next = val_reg;
        lo_next  = lo_reg;
        sig_next = sig_reg;
        run_next = run_reg;
        err_next = err_reg;

        if (err_reg == b58d_pkg::ST_OK)
        begin
            if (!dg.ok)
                err_next = b58d_pkg::ST_INVALID;
            else if (run_reg && dg.digit == 6'd0)
            begin
                if (lo_reg >= b58d_pkg::LO_W'(b58d_pkg::MAX_BYTES))
                    err_next = b58d_pkg::ST_OVERFLOW;
                else
                    lo_next = lo_reg + 1'b1;
            end
            else
            begin
                run_next = 1'b0;
                val_next = prod_bytes;
                // value grows by under one byte per digit
                if (sig_reg < b58d_pkg::LO_W'(b58d_pkg::MAX_BYTES)
                    && prod_bytes[sig_reg[b58d_pkg::BIDX_W-1:0]] != 8'd0)
                    sig_next = sig_reg + 1'b1;
                if (|prod[b58d_pkg::PROD_W-1:b58d_pkg::VAL_W])
                    err_next = b58d_pkg::ST_OVERFLOW;
            end
        end

        total      = b58d_pkg::TOT_W'(lo_next) + b58d_pkg::TOT_W'(sig_next);
        snap.value = val_next;
        snap.sig   = sig_next;
        snap.total = total;
        if (err_next != b58d_pkg::ST_OK)
            snap.err = err_next;
        else if (total > b58d_pkg::TOT_W'(b58d_pkg::MAX_BYTES))
            snap.err = b58d_pkg::ST_OVERFLOW;
        else
            snap.err = b58d_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            lo_reg  <= '0;
            sig_reg <= '0;
            run_reg <= 1'b1;
            err_reg <= b58d_pkg::ST_OK;
        end
        else if (fire)
        begin
            if (req.is_last)
            begin
                val_reg <= '0;
                lo_reg  <= '0;
                sig_reg <= '0;
                run_reg <= 1'b1;
                err_reg <= b58d_pkg::ST_OK;
            end
            else
            begin
                val_reg <= val_next;
                lo_reg  <= lo_next;
                sig_reg <= sig_next;
                run_reg <= run_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

@@ design/b58d_emit.sv @@
// Result sequencer: walks a finished string out into an output register, one byte per cycle while rsp_ready allows.
module b58d_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  b58d_pkg::snap_t      snap,
    output logic                 busy,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output b58d_pkg::byte_rsp_t  rsp
);

    logic                            busy_reg;
    b58d_pkg::status_t               err_reg;
    logic [b58d_pkg::TOT_W-1:0]      idx_reg;
    logic [b58d_pkg::LO_W-1:0]       sig_reg;
    b58d_pkg::value_t                val_reg;
    b58d_pkg::byte_rsp_t             out_reg, item;
    logic                            out_valid_reg;
    logic                            adv, done;

    always_comb
    begin
        adv  = busy_reg && (!out_valid_reg || rsp_ready);
        done = (err_reg != b58d_pkg::ST_OK) || (idx_reg == '0);
        if (err_reg != b58d_pkg::ST_OK)
        begin
            item.out_byte = 8'd0;
            item.status   = err_reg;
            item.last_out = 1'b1;
        end
        else
        begin
            // positions at or above the significant length are the leading zeros
            if (idx_reg < b58d_pkg::TOT_W'(sig_reg))
                item.out_byte = val_reg[idx_reg[b58d_pkg::BIDX_W-1:0]];
            else
                item.out_byte = 8'd0;
            item.status   = b58d_pkg::ST_OK;
            item.last_out = (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            err_reg       <= b58d_pkg::ST_OK;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= (snap.err != b58d_pkg::ST_OK) || (snap.total != '0);
                err_reg  <= snap.err;
            end
            else if (adv && done)
                busy_reg <= 1'b0;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg <= snap.total - 1'b1;
            sig_reg <= snap.sig;
            val_reg <= snap.value;
        end
        else if (adv && !done)
            idx_reg <= idx_reg - 1'b1;

        if (adv)
            out_reg <= item;
    end

    assign busy      = busy_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

@@ design/base58_decoder_unit.sv @@
// Top level of the streaming Base58 (Bitcoin alphabet) decoder.
// Throughput: one character request per cycle; the mul-by-58 add updates the number in place.
// A last-character request waits only while the previous string's results are still draining.
// The snapshot is registered in the emitter, then each byte in the output register; one per cycle as byte_ready allows.
// A string emits leading-zero count + significant bytes, or one status result on error.
// Reset (rst_n, async, active low) clears the number, counters, error and output valid.
module base58_decoder_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  b58d_pkg::char_req_t  char_item,
    output logic                 byte_valid,
    input  logic                 byte_ready,
    output b58d_pkg::byte_rsp_t  byte_item
);

    logic             fire;
    logic             busy;
    b58d_pkg::snap_t  snap;

    // Non-last characters always go straight into the accumulator. A last
    // character must hand its snapshot to the emitter, so hold it while
    // the emitter is still walking out the previous string.
    assign char_ready = !(char_item.is_last && busy);
    assign fire       = char_valid && char_ready;

    // Accumulate digits; the snapshot reflects the state after this request
    b58d_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (char_item),
        .snap  (snap)
    );

    // Capture the finished string and drive the result register
    b58d_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && char_item.is_last),
        .snap      (snap),
        .busy      (busy),
        .rsp_valid (byte_valid),
        .rsp_ready (byte_ready),
        .rsp       (byte_item)
    );

endmodule

@@ design/b58d_checker.sv @@
// Port-level checker for the Base58 decoder, bound to the top level.
module b58d_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 char_valid,
    input logic                 char_ready,
    input b58d_pkg::char_req_t  char_item,
    input logic                 byte_valid,
    input logic                 byte_ready,
    input b58d_pkg::byte_rsp_t  byte_item
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(byte_item))
        else $error("result changed while stalled");

    // Only a last character can ever be stalled
    a_mid_ready: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_item.is_last |-> char_ready)
        else $error("non-last character stalled");

    // Status results carry a zero byte and close the string
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_item.status != b58d_pkg::ST_OK
            |-> byte_item.out_byte == 8'd0 && byte_item.last_out)
        else $error("malformed status result");

    // Bytes of one string follow without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && !byte_item.last_out |=> byte_valid)
        else $error("gap inside a string's results");

endmodule

bind base58_decoder_unit b58d_checker u_b58d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item)
);
